### rtl/tcsc_pkg.sv
package tcsc_pkg;

    localparam int MAX_COLUMNS_DEF = 256;
    localparam int MAX_ROWS_DEF    = 128;
    localparam int RST_COLUMNS     = 80;
    localparam int RST_ROWS        = 24;
    localparam int QUEUE_DEPTH     = 2;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;

    localparam logic [3:0] OP_UP     = 4'd0;
    localparam logic [3:0] OP_DOWN   = 4'd1;
    localparam logic [3:0] OP_RIGHT  = 4'd2;
    localparam logic [3:0] OP_LEFT   = 4'd3;
    localparam logic [3:0] OP_MOVE   = 4'd4;
    localparam logic [3:0] OP_REGION = 4'd5;
    localparam logic [3:0] OP_LF     = 4'd6;
    localparam logic [3:0] OP_RI     = 4'd7;
    localparam logic [3:0] OP_CR     = 4'd8;
    localparam logic [3:0] OP_CELL   = 4'd9;
    localparam logic [3:0] OP_ICH    = 4'd10;
    localparam logic [3:0] OP_DCH    = 4'd11;
    localparam logic [3:0] OP_IL     = 4'd12;
    localparam logic [3:0] OP_DL     = 4'd13;

    localparam logic [3:0] ACT_NONE   = 4'd0;
    localparam logic [3:0] ACT_WRITE  = 4'd1;
    localparam logic [3:0] ACT_SU     = 4'd2;
    localparam logic [3:0] ACT_SD     = 4'd3;
    localparam logic [3:0] ACT_ICH    = 4'd4;
    localparam logic [3:0] ACT_DCH    = 4'd5;
    localparam logic [3:0] ACT_IL     = 4'd6;
    localparam logic [3:0] ACT_DL     = 4'd7;
    localparam logic [3:0] ACT_CURSOR = 4'd8;

    typedef enum logic [3:0] {
        K_UP, K_DOWN, K_RIGHT, K_LEFT, K_MOVE, K_REGION, K_LF, K_RI,
        K_CR, K_CELL, K_ICH, K_DCH, K_IL, K_DL, K_NOP
    } t_kind;

    typedef struct packed {
        logic [3:0] opcode;
        logic [7:0] arg_a;
        logic [6:0] arg_b;
        logic [1:0] char_width;
    } t_cmd_item;

    typedef struct packed {
        logic [3:0] action;
        logic [7:0] pos_x;
        logic [6:0] pos_y;
        logic [7:0] amount;
        logic [6:0] region_top;
        logic [6:0] region_bottom;
        logic       within_region;
        logic       substituted;
        logic [8:0] cursor_col;
        logic [6:0] cursor_row;
        logic       last;
    } t_res_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] arg_a;
        logic [6:0] arg_b;
        logic [7:0] cnt;
        logic [1:0] w;
        logic       subst;
    } t_op;

endpackage

### rtl/tcsc_stream_if.sv
interface tcsc_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

### rtl/terminal_cursor_scroll_control.sv
// Each accepted item passes through the command queue and the result register before its result is valid.
// Throughput: one item per cycle while the output is not held by back-pressure; a cell write whose wrap
// scrolls the region occupies the cursor unit for two results (the scroll, then the write).
// Reset: cursor home, region covers the screen, 80 columns by 24 rows
// (each limited to its maximum), command queue and output empty.
module terminal_cursor_scroll_control #(
    parameter int MAX_COLUMNS = tcsc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = tcsc_pkg::MAX_ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tcsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tcsc_pkg::CFG_W-1:0]     i_cfg_data,
    tcsc_stream_if.sink                    i_cmd,
    tcsc_stream_if.source                  o_res
);
    import tcsc_pkg::*;

    logic                            q_ready, push, pop, q_valid;
    t_op                             push_op, head_op;
    logic [$clog2(MAX_COLUMNS+1)-1:0] cols;

    tcsc_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
        .i_cmd     (i_cmd),
        .i_cols    (cols),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_op      (push_op)
    );

    tcsc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_op    (push_op),
        .o_push_ready (q_ready),
        .o_pop_valid  (q_valid),
        .o_pop_op     (head_op),
        .i_pop        (pop)
    );

    tcsc_back #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op_valid  (q_valid),
        .i_op        (head_op),
        .o_pop       (pop),
        .o_cols      (cols),
        .o_res       (o_res)
    );

endmodule

### rtl/tcsc_front.sv
module tcsc_front #(
    parameter int MAX_COLUMNS = tcsc_pkg::MAX_COLUMNS_DEF
) (
    tcsc_stream_if.sink                        i_cmd,
    input  logic [$clog2(MAX_COLUMNS+1)-1:0]   i_cols,
    input  logic                               i_q_ready,
    output logic                               o_push,
    output tcsc_pkg::t_op                      o_op
);
    import tcsc_pkg::*;

    t_cmd_item c;

    assign c           = i_cmd.data;
    assign i_cmd.ready = i_q_ready;
    assign o_push      = i_cmd.valid & i_q_ready;

    always_comb begin
        o_op.arg_a = c.arg_a;
        o_op.arg_b = c.arg_b;
        o_op.cnt   = (c.arg_a == 8'd0) ? 8'd1 : c.arg_a;
        o_op.w     = c.char_width;
        o_op.subst = 1'b0;
        case (c.opcode)
            OP_UP:     o_op.kind = K_UP;
            OP_DOWN:   o_op.kind = K_DOWN;
            OP_RIGHT:  o_op.kind = K_RIGHT;
            OP_LEFT:   o_op.kind = K_LEFT;
            OP_MOVE:   o_op.kind = K_MOVE;
            OP_REGION: o_op.kind = K_REGION;
            OP_LF:     o_op.kind = K_LF;
            OP_RI:     o_op.kind = K_RI;
            OP_CR:     o_op.kind = K_CR;
            OP_CELL: begin
                if (c.char_width == 2'd0) begin
                    o_op.kind = K_NOP;
                end else begin
                    o_op.kind = K_CELL;
                    if (32'(c.char_width) > 32'(i_cols)) begin
                        o_op.w     = 2'd1;
                        o_op.subst = 1'b1;
                    end
                end
            end
            OP_ICH:    o_op.kind = K_ICH;
            OP_DCH:    o_op.kind = K_DCH;
            OP_IL:     o_op.kind = K_IL;
            OP_DL:     o_op.kind = K_DL;
            default:   o_op.kind = K_NOP;
        endcase
    end

endmodule

### rtl/tcsc_queue.sv
module tcsc_queue #(
    parameter int DEPTH = tcsc_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcsc_pkg::t_op i_push_op,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output tcsc_pkg::t_op o_pop_op,
    input  logic          i_pop
);
    import tcsc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_op           r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [NW-1:0] r_cnt, n_cnt;

    assign o_push_ready = (32'(r_cnt) < DEPTH);
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_op     = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (32'(r_wr) == DEPTH - 1) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (32'(r_rd) == DEPTH - 1) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_op;
        end
    end

endmodule

### rtl/tcsc_back.sv
module tcsc_back #(
    parameter int MAX_COLUMNS = tcsc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = tcsc_pkg::MAX_ROWS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tcsc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tcsc_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_op_valid,
    input  tcsc_pkg::t_op                      i_op,
    output logic                               o_pop,
    output logic [$clog2(MAX_COLUMNS+1)-1:0]   o_cols,
    tcsc_stream_if.source                      o_res
);
    import tcsc_pkg::*;

    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int RST_C = (RST_COLUMNS > MAX_COLUMNS) ? MAX_COLUMNS : RST_COLUMNS;
    localparam int RST_R = (RST_ROWS > MAX_ROWS) ? MAX_ROWS : RST_ROWS;

    logic [CW-1:0] r_cols, r_col, n_col, clast, col_room, ncol_take, cfg_cols;
    logic [RW-1:0] r_rows, r_row, n_row, rlast, row_room, nrow_take, cfg_rows;
    logic [RW-1:0] r_top, n_top, r_bot, n_bot, cl_a, cl_b;
    logic          r_ovalid, fire, pop_ok;
    t_res_item     r_res, res;

    assign o_cols      = r_cols;
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_res;
    assign fire        = i_op_valid && (!r_ovalid || o_res.ready);
    assign o_pop       = fire && pop_ok;

    assign clast    = r_cols - CW'(1);
    assign rlast    = r_rows - RW'(1);
    assign col_room = (r_col >= clast) ? '0 : clast - r_col;
    assign row_room = (r_row >= rlast) ? '0 : rlast - r_row;

    always_comb begin
        ncol_take = (32'(i_op.cnt) > 32'(col_room)) ? col_room : CW'(i_op.cnt);
        nrow_take = (32'(i_op.cnt) > 32'(row_room)) ? row_room : RW'(i_op.cnt);
        cl_a      = (32'(i_op.arg_a) > 32'(rlast)) ? rlast : RW'(i_op.arg_a);
        cl_b      = (32'(i_op.arg_b) > 32'(rlast)) ? rlast : RW'(i_op.arg_b);
    end

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_cols = CW'(1);
        end else if (32'(i_cfg_data) > MAX_COLUMNS) begin
            cfg_cols = CW'(MAX_COLUMNS);
        end else begin
            cfg_cols = CW'(i_cfg_data);
        end
        if (i_cfg_data[7:0] == 8'd0) begin
            cfg_rows = RW'(1);
        end else if (32'(i_cfg_data[7:0]) > MAX_ROWS) begin
            cfg_rows = RW'(MAX_ROWS);
        end else begin
            cfg_rows = RW'(i_cfg_data[7:0]);
        end
    end

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_top  = r_top;
        n_bot  = r_bot;
        pop_ok = 1'b1;
        res    = '0;
        res.action = ACT_CURSOR;
        res.last   = 1'b1;
        case (i_op.kind)
            K_UP:    n_row = r_row - ((32'(i_op.cnt) > 32'(r_row)) ? r_row : RW'(i_op.cnt));
            K_DOWN:  n_row = r_row + nrow_take;
            K_RIGHT: n_col = r_col + ncol_take;
            K_LEFT:  n_col = r_col - ((32'(i_op.cnt) > 32'(r_col)) ? r_col : CW'(i_op.cnt));
            K_MOVE: begin
                n_col = (32'(i_op.arg_a) > 32'(clast)) ? clast : CW'(i_op.arg_a);
                n_row = cl_b;
            end
            K_REGION: begin
                if (cl_a > cl_b) begin
                    res.action = ACT_NONE;
                end else begin
                    n_col = '0;
                    n_row = '0;
                    n_top = cl_a;
                    n_bot = cl_b;
                end
            end
            K_LF: begin
                if (r_row == r_bot) begin
                    res.action = ACT_SU;
                    res.pos_y  = 7'(r_row);
                    res.amount = 8'd1;
                end else if (r_row < rlast) begin
                    n_row = r_row + RW'(1);
                end
            end
            K_RI: begin
                if (r_row == r_top) begin
                    res.action = ACT_SD;
                    res.pos_y  = 7'(r_row);
                    res.amount = 8'd1;
                end else if (r_row != '0) begin
                    n_row = r_row - RW'(1);
                end
            end
            K_CR: n_col = '0;
            K_CELL: begin
                res.action      = ACT_WRITE;
                res.amount      = 8'(i_op.w);
                res.substituted = i_op.subst;
                if (32'(r_col) + 32'(i_op.w) > 32'(r_cols)) begin
                    n_col = '0;
                    if (r_row == r_bot) begin
                        // scroll first, cell goes out on the next pass
                        res        = '0;
                        res.action = ACT_SU;
                        res.pos_y  = 7'(r_row);
                        res.amount = 8'd1;
                        pop_ok     = 1'b0;
                    end else begin
                        if (r_row < rlast) begin
                            n_row = r_row + RW'(1);
                        end
                        res.pos_x = 8'd0;
                        res.pos_y = 7'(n_row);
                        n_col     = CW'(i_op.w);
                    end
                end else begin
                    res.pos_x = 8'(r_col);
                    res.pos_y = 7'(r_row);
                    n_col     = r_col + CW'(i_op.w);
                end
            end
            K_ICH, K_DCH: begin
                if (ncol_take == '0) begin
                    res.action = ACT_NONE;
                end else begin
                    res.action = (i_op.kind == K_ICH) ? ACT_ICH : ACT_DCH;
                    res.pos_x  = 8'(r_col);
                    res.pos_y  = 7'(r_row);
                    res.amount = 8'(ncol_take);
                end
            end
            K_IL, K_DL: begin
                if (nrow_take == '0) begin
                    res.action = ACT_NONE;
                end else begin
                    res.action        = (i_op.kind == K_IL) ? ACT_IL : ACT_DL;
                    res.pos_y         = 7'(r_row);
                    res.amount        = 8'(nrow_take);
                    res.within_region = r_row inside {[r_top:r_bot]};
                end
            end
            default: res.action = ACT_NONE;
        endcase
        res.last          = pop_ok;
        res.region_top    = 7'(n_top);
        res.region_bottom = 7'(n_bot);
        res.cursor_col    = 9'(n_col);
        res.cursor_row    = 7'(n_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols   <= CW'(RST_C);
            r_rows   <= RW'(RST_R);
            r_col    <= '0;
            r_row    <= '0;
            r_top    <= '0;
            r_bot    <= RW'(RST_R - 1);
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= fire || (r_ovalid && !o_res.ready);
            if (i_cfg_we && i_cfg_index == CFG_COLUMNS) begin
                r_cols <= cfg_cols;
                if (r_col > cfg_cols) begin
                    r_col <= cfg_cols;
                end
            end else if (i_cfg_we && i_cfg_index == CFG_ROWS) begin
                r_rows <= cfg_rows;
                if (r_row > cfg_rows - RW'(1)) begin
                    r_row <= cfg_rows - RW'(1);
                end
                r_top <= '0;
                r_bot <= cfg_rows - RW'(1);
            end else if (fire) begin
                r_col <= n_col;
                r_row <= n_row;
                r_top <= n_top;
                r_bot <= n_bot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= res;
        end
    end

endmodule
